// ===== src/mcn_pkg.sv =====
`default_nettype none

package mcn_pkg;

  // Largest list the navigator browses; a larger entry count is clamped to it.
  localparam int unsigned MaxEntries = 1024;

  localparam int unsigned CountW  = 11;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned RowsW   = 7;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned DelayW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned ButtonW = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegEntryCount   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVisibleRows  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPressLevel   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegReleaseLevel = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFirstDelay   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNextDelay    = 3'd5;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_PICK   = 2'd1,
    ACT_CANCEL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic              button_a;
    logic              button_b;
    logic              button_start;
    logic              trigger_z;
    logic              trigger_r;
    logic              pad_up;
    logic              pad_down;
    logic signed [7:0] stick_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [IndexW-1:0] cursor_index;
    logic [IndexW-1:0] window_top;
  } out_word_t;

  typedef struct packed {
    logic [CountW-1:0] entry_count;
    logic [RowsW-1:0]  visible_rows;
    logic [LevelW-1:0] stick_press_level;
    logic [LevelW-1:0] stick_release_level;
    logic [DelayW-1:0] repeat_first_delay;
    logic [DelayW-1:0] repeat_next_delay;
  } cfg_t;

  typedef struct packed {
    logic [ButtonW-1:0] prev_buttons;
    dir_e               rep_dir;
    logic [DelayW-1:0]  countdown;
    logic [IndexW-1:0]  cursor;
    logic [IndexW-1:0]  top_row;
  } nav_state_t;

endpackage

`default_nettype wire

// ===== src/mcn_cfg_regs.sv =====
`default_nettype none

module mcn_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mcn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mcn_pkg::CfgW-1:0]     cfg_data_i,
  output mcn_pkg::cfg_t                     cfg_o
);

  mcn_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_count         <= '0;
      cfg_q.visible_rows        <= 7'd1;
      cfg_q.stick_press_level   <= 7'd64;
      cfg_q.stick_release_level <= 7'd32;
      cfg_q.repeat_first_delay  <= 8'd20;
      cfg_q.repeat_next_delay   <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcn_pkg::RegEntryCount:   cfg_q.entry_count <= cfg_data_i[mcn_pkg::CountW-1:0];
        mcn_pkg::RegVisibleRows:  cfg_q.visible_rows <= cfg_data_i[mcn_pkg::RowsW-1:0];
        mcn_pkg::RegPressLevel:
          cfg_q.stick_press_level <= cfg_data_i[mcn_pkg::LevelW-1:0];
        mcn_pkg::RegReleaseLevel:
          cfg_q.stick_release_level <= cfg_data_i[mcn_pkg::LevelW-1:0];
        mcn_pkg::RegFirstDelay:
          cfg_q.repeat_first_delay <= cfg_data_i[mcn_pkg::DelayW-1:0];
        mcn_pkg::RegNextDelay:
          cfg_q.repeat_next_delay <= cfg_data_i[mcn_pkg::DelayW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/mcn_window.sv =====
`default_nettype none

// Keeps the visible window around a cursor that already lies inside the list.
module mcn_window (
  input  wire logic [mcn_pkg::IndexW-1:0] cursor_i,
  input  wire logic [mcn_pkg::IndexW-1:0] top_i,
  input  wire logic [mcn_pkg::RowsW-1:0]  rows_i,
  input  wire logic [mcn_pkg::CountW-1:0] count_i,
  output logic      [mcn_pkg::IndexW-1:0] top_o
);

  logic signed [12:0] cur_s;
  logic signed [12:0] top_s;
  logic signed [12:0] rows_s;
  logic signed [12:0] lim_s;
  logic signed [12:0] t1;
  logic signed [12:0] t2;

  assign cur_s  = $signed({3'b000, cursor_i});
  assign top_s  = $signed({3'b000, top_i});
  assign rows_s = $signed({6'b000000, rows_i});
  assign lim_s  = $signed({2'b00, count_i}) - rows_s;

  always_comb begin
    // Pull the top up to the cursor, or down so the cursor sits on the last row.
    if (cur_s < top_s) begin
      t1 = cur_s;
    end else if (cur_s >= top_s + rows_s) begin
      t1 = cur_s - rows_s + 13'sd1;
    end else begin
      t1 = top_s;
    end
    // Do not scroll past the end of the list, and never above the first entry.
    t2 = (t1 > lim_s) ? lim_s : t1;
    if (t2 < 13'sd0) begin
      t2 = 13'sd0;
    end
  end

  assign top_o = t2[mcn_pkg::IndexW-1:0];

endmodule

`default_nettype wire

// ===== src/mcn_frame_logic.sv =====
`default_nettype none

// Decides pick, cancel, page or move for one frame and forms the next state.
module mcn_frame_logic (
  input  wire mcn_pkg::cfg_t       cfg_i,
  input  wire mcn_pkg::nav_state_t state_i,
  input  wire mcn_pkg::in_word_t   frame_i,
  output mcn_pkg::nav_state_t      state_o,
  output mcn_pkg::out_word_t       result_o
);

  logic [mcn_pkg::CountW-1:0]  count;
  logic [mcn_pkg::RowsW-1:0]   rows;
  logic [mcn_pkg::ButtonW-1:0] now;
  logic [mcn_pkg::ButtonW-1:0] pressed;
  logic                        pick;
  logic                        cancel;
  logic                        page;
  logic signed [12:0]          cur_s;
  logic signed [12:0]          rows_s;
  logic signed [12:0]          count_s;
  logic signed [12:0]          pg_raw;
  logic signed [12:0]          pg;
  logic signed [12:0]          mv_raw;
  logic signed [12:0]          mv;
  logic [mcn_pkg::LevelW-1:0]  level;
  logic signed [8:0]           y9;
  logic signed [8:0]           lvl9;
  logic                        go_up;
  logic                        go_down;
  mcn_pkg::dir_e               code;
  logic [mcn_pkg::IndexW-1:0]  new_cursor;
  logic [mcn_pkg::IndexW-1:0]  new_top;

  assign count = (cfg_i.entry_count > mcn_pkg::CountW'(mcn_pkg::MaxEntries))
               ? mcn_pkg::CountW'(mcn_pkg::MaxEntries) : cfg_i.entry_count;
  assign rows  = (cfg_i.visible_rows == '0) ? 7'd1 : cfg_i.visible_rows;

  // Button order in the history: A, B, Start, Z, R from bit 0 up.
  assign now     = {frame_i.trigger_r, frame_i.trigger_z, frame_i.button_start,
                    frame_i.button_b, frame_i.button_a};
  assign pressed = now & ~state_i.prev_buttons;
  assign pick    = (count != '0) && (pressed[0] || pressed[2]);
  assign cancel  = pressed[1];
  assign page    = pressed[3] || pressed[4];

  assign cur_s   = $signed({3'b000, state_i.cursor});
  assign rows_s  = $signed({6'b000000, rows});
  assign count_s = $signed({2'b00, count});

  // Paging clamps at both ends of the list; Z wins over R.
  assign pg_raw = pressed[3] ? (cur_s - rows_s) : (cur_s + rows_s);
  always_comb begin
    if (pg_raw < 13'sd0) begin
      pg = 13'sd0;
    end else if (pg_raw >= count_s) begin
      pg = count_s - 13'sd1;
    end else begin
      pg = pg_raw;
    end
  end

  // Stick hysteresis: the release level applies while a direction is held.
  assign level   = (state_i.rep_dir != mcn_pkg::DIR_NONE)
                 ? cfg_i.stick_release_level : cfg_i.stick_press_level;
  assign y9      = $signed({frame_i.stick_y[7], frame_i.stick_y});
  assign lvl9    = $signed({2'b00, level});
  assign go_up   = frame_i.pad_up || (y9 >= lvl9);
  assign go_down = frame_i.pad_down || (y9 <= -lvl9);
  assign code    = go_up ? mcn_pkg::DIR_UP : mcn_pkg::DIR_DOWN;

  // Single steps wrap at the list ends; a stale cursor past the end wraps to 0.
  assign mv_raw = go_up ? (cur_s - 13'sd1) : (cur_s + 13'sd1);
  always_comb begin
    if (mv_raw < 13'sd0) begin
      mv = count_s - 13'sd1;
    end else if (mv_raw >= count_s) begin
      mv = 13'sd0;
    end else begin
      mv = mv_raw;
    end
  end

  assign new_cursor = page ? pg[mcn_pkg::IndexW-1:0] : mv[mcn_pkg::IndexW-1:0];

  mcn_window u_window (
    .cursor_i (new_cursor),
    .top_i    (state_i.top_row),
    .rows_i   (rows),
    .count_i  (count),
    .top_o    (new_top)
  );

  always_comb begin
    state_o              = state_i;
    state_o.prev_buttons = now;
    result_o.action      = mcn_pkg::ACT_NONE;
    if (pick) begin
      result_o.action = mcn_pkg::ACT_PICK;
    end else if (cancel) begin
      result_o.action = mcn_pkg::ACT_CANCEL;
    end else if (count == '0) begin
      state_o.rep_dir   = mcn_pkg::DIR_NONE;
      state_o.countdown = '0;
    end else if (page) begin
      state_o.cursor  = new_cursor;
      state_o.top_row = new_top;
    end else if (!go_up && !go_down) begin
      state_o.rep_dir   = mcn_pkg::DIR_NONE;
      state_o.countdown = '0;
    end else if (code != state_i.rep_dir) begin
      state_o.rep_dir   = code;
      state_o.countdown = cfg_i.repeat_first_delay;
      state_o.cursor    = new_cursor;
      state_o.top_row   = new_top;
    end else if (state_i.countdown <= 8'd1) begin
      state_o.countdown = cfg_i.repeat_next_delay;
      state_o.cursor    = new_cursor;
      state_o.top_row   = new_top;
    end else begin
      state_o.countdown = state_i.countdown - 8'd1;
    end
    result_o.cursor_index = state_o.cursor;
    result_o.window_top   = state_o.top_row;
  end

endmodule

`default_nettype wire

// ===== src/menu_cursor_navigator.sv =====
// Menu cursor navigator: turns one controller frame per input word into a
// menu action and the cursor and window position that follow from it.
// Input channel: in_valid_i / in_stall_o with in_word_i (buttons, pad and the
// signed stick axis). A word is taken at a rising edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i with out_word_o
// (action, cursor_index, window_top), one output word per input word.
// The frame is registered, then the decision logic runs against the
// navigation state and the result lands in the output register. Throughput
// is one word per cycle while the receiver does not stall; the limit is the
// combinational decision and window logic path that updates the state.
// When the receiver stalls, the output word holds and the input register
// keeps its word; a new word is still taken while the input register is
// empty or drains into the output register in the same cycle.
// The configuration port writes one register per cycle with cfg_we_i; the user
// must write it only while no word is in flight; the block does not enforce this.
// Reset clears the button history, repeat state, cursor and window top to
// zero and loads the register defaults; both channels come up empty.
`default_nettype none

module menu_cursor_navigator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire mcn_pkg::in_word_t           in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output mcn_pkg::out_word_t               out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [mcn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [mcn_pkg::CfgW-1:0]    cfg_data_i
);

  mcn_pkg::cfg_t       cfg;
  mcn_pkg::in_word_t   in_word_q;
  logic                in_valid_q;
  mcn_pkg::nav_state_t state_q;
  mcn_pkg::nav_state_t state_d;
  mcn_pkg::out_word_t  result_d;
  mcn_pkg::out_word_t  out_word_q;
  logic                out_valid_q;
  logic                out_free;
  logic                advance;
  logic                in_take;

  mcn_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mcn_frame_logic u_frame_logic (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .frame_i  (in_word_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The output register can take a result when it is empty or being read.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A processed frame always produces an output word.
  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed frame did not reach the output register");

  // Navigation state only moves when a frame is processed.
  a_state_only_on_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("navigation state changed without a frame");

  // A blocked output keeps the pending frame in the input register.
  a_pending_frame_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |=> in_valid_q)
    else $error("pending frame lost while output was stalled");

  // Pick and cancel leave the cursor where it was.
  a_action_keeps_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (result_d.action == mcn_pkg::ACT_PICK ||
                 result_d.action == mcn_pkg::ACT_CANCEL)) |=> $stable(state_q.cursor))
    else $error("cursor moved on pick or cancel");

endmodule

`default_nettype wire
